### rtl/dali_frame_transceiver_core_defines.svh
// Assertion macros shared by the transceiver RTL
`ifndef DALI_FRAME_TRANSCEIVER_CORE_DEFINES_SVH
`define DALI_FRAME_TRANSCEIVER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising edge, off during reset
`define DALIFT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising edge, off during reset
`define DALIFT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/dalift_pkg.sv
package dalift_pkg;

    localparam int COUNT_WIDTH = 24;
    localparam int ANSWER_BITS = 8;
    localparam int HALF_WIDTH  = 16;
    localparam int FRAME_BITS  = 16;
    localparam int STOP_HALVES = 4;
    localparam int DELAY_HALVES = 3;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 24;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_HALF_BIT   = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TIMEOUT    = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_OFFSET     = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_GAP        = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_INVERT_TX  = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_INVERT_RX  = 3'd5;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_SEND     = 3'd1,
        PH_STOP     = 3'd2,
        PH_WAIT     = 3'd3,
        PH_DELAY    = 3'd4,
        PH_RECV     = 3'd5,
        PH_GAP      = 3'd6,
        PH_GAP_NONE = 3'd7
    } phase_t;

    typedef struct packed {
        logic [HALF_WIDTH-1:0]  half_bit_ticks;
        logic [COUNT_WIDTH-1:0] answer_timeout_ticks;
        logic [HALF_WIDTH-1:0]  sample_offset_ticks;
        logic [COUNT_WIDTH-1:0] frame_gap_ticks;
        logic                   invert_tx;
        logic                   invert_rx;
    } cfg_t;

    typedef struct packed {
        logic       start_req;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic       expect_answer;
        logic       line_in;
    } item_t;

    typedef struct packed {
        logic                   line_out;
        logic                   busy_res;
        logic                   done_res;
        logic [ANSWER_BITS-1:0] answer;
        logic                   timed_out;
    } res_t;

endpackage

### rtl/dalift_engine.sv
module dalift_engine (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  dalift_pkg::cfg_t  cfg,
    input  dalift_pkg::item_t item,
    output dalift_pkg::res_t  res
);

    localparam int CW = dalift_pkg::COUNT_WIDTH;
    localparam int AB = dalift_pkg::ANSWER_BITS;
    localparam int FB = dalift_pkg::FRAME_BITS;

    dalift_pkg::phase_t phase_reg, phase_next;
    logic [CW-1:0] tick_reg, tick_next;
    logic [4:0]    bit_reg, bit_next;
    logic [FB-1:0] send_reg, send_next;
    logic [AB-1:0] recv_reg, recv_next;
    logic          wanted_reg, wanted_next;
    logic          half_reg, half_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= dalift_pkg::PH_IDLE;
            tick_reg   <= '0;
            bit_reg    <= '0;
            send_reg   <= '0;
            recv_reg   <= '0;
            wanted_reg <= 1'b0;
            half_reg   <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            tick_reg   <= tick_next;
            bit_reg    <= bit_next;
            send_reg   <= send_next;
            recv_reg   <= recv_next;
            wanted_reg <= wanted_next;
            half_reg   <= half_next;
        end
    end

    always_comb
    begin
        logic [CW-1:0] half_len;
        logic [CW-1:0] tick_inc;
        logic          half_end;
        logic          rx;
        logic          send_bit;
        logic          level;
        logic [4:0]    dly_bit;
        logic [CW-1:0] dly_tick;

        rx = item.line_in ^ cfg.invert_rx;
        half_len = (cfg.half_bit_ticks == '0) ? CW'(1) : CW'(cfg.half_bit_ticks);

        phase_next  = phase_reg;
        tick_next   = tick_reg;
        bit_next    = bit_reg;
        send_next   = send_reg;
        recv_next   = recv_reg;
        wanted_next = wanted_reg;
        half_next   = half_reg;

        // a start while idle is loaded and worked in the same tick
        if (phase_reg == dalift_pkg::PH_IDLE && item.start_req)
        begin
            send_next   = {item.first_byte, item.second_byte};
            wanted_next = item.expect_answer;
            recv_next   = '0;
            tick_next   = '0;
            bit_next    = '0;
            half_next   = 1'b0;
            phase_next  = dalift_pkg::PH_SEND;
        end

        tick_inc = tick_next + CW'(1);
        half_end = (tick_inc >= half_len);
        level    = 1'b1;
        send_bit = 1'b1;
        dly_bit  = bit_next;
        dly_tick = tick_inc;

        res.busy_res  = (phase_next != dalift_pkg::PH_IDLE);
        res.done_res  = 1'b0;
        res.answer    = '0;
        res.timed_out = 1'b0;

        unique case (phase_next)
            dalift_pkg::PH_IDLE:
            begin
            end
            dalift_pkg::PH_SEND:
            begin
                if (bit_next != '0)
                begin
                    send_bit = send_next[4'(5'd16 - bit_next)];
                end
                level = half_next ? send_bit : ~send_bit;
                tick_next = half_end ? '0 : tick_inc;
                if (half_end)
                begin
                    if (!half_next)
                    begin
                        half_next = 1'b1;
                    end
                    else
                    begin
                        half_next = 1'b0;
                        if (bit_next >= 5'(FB))
                        begin
                            bit_next   = '0;
                            phase_next = dalift_pkg::PH_STOP;
                        end
                        else
                        begin
                            bit_next = bit_next + 5'd1;
                        end
                    end
                end
            end
            dalift_pkg::PH_STOP:
            begin
                tick_next = half_end ? '0 : tick_inc;
                if (half_end)
                begin
                    if (bit_next + 5'd1 >= 5'(dalift_pkg::STOP_HALVES))
                    begin
                        bit_next = '0;
                        if (wanted_next)
                        begin
                            phase_next = dalift_pkg::PH_WAIT;
                        end
                        else
                        begin
                            res.done_res = 1'b1;
                            phase_next   = dalift_pkg::PH_IDLE;
                        end
                    end
                    else
                    begin
                        bit_next = bit_next + 5'd1;
                    end
                end
            end
            dalift_pkg::PH_WAIT:
            begin
                if (!rx)
                begin
                    tick_next  = '0;
                    bit_next   = '0;
                    phase_next = dalift_pkg::PH_DELAY;
                end
                else if (tick_inc >= cfg.answer_timeout_ticks)
                begin
                    tick_next  = '0;
                    recv_next  = '0;
                    phase_next = dalift_pkg::PH_GAP_NONE;
                end
                else
                begin
                    tick_next = tick_inc;
                end
            end
            dalift_pkg::PH_DELAY:
            begin
                if (dly_bit < 5'(dalift_pkg::DELAY_HALVES) && half_end)
                begin
                    dly_tick = '0;
                    dly_bit  = dly_bit + 5'd1;
                end
                if (dly_bit >= 5'(dalift_pkg::DELAY_HALVES)
                    && dly_tick >= CW'(cfg.sample_offset_ticks))
                begin
                    recv_next  = AB'(rx);
                    bit_next   = 5'd1;
                    half_next  = 1'b0;
                    tick_next  = '0;
                    phase_next = dalift_pkg::PH_RECV;
                end
                else
                begin
                    tick_next = dly_tick;
                    bit_next  = dly_bit;
                end
            end
            dalift_pkg::PH_RECV:
            begin
                tick_next = half_end ? '0 : tick_inc;
                if (half_end)
                begin
                    if (!half_next)
                    begin
                        half_next = 1'b1;
                    end
                    else
                    begin
                        half_next = 1'b0;
                        if (bit_next >= 5'(AB))
                        begin
                            phase_next = dalift_pkg::PH_GAP;
                        end
                        else
                        begin
                            recv_next = {recv_next[AB-2:0], rx};
                            bit_next  = bit_next + 5'd1;
                        end
                    end
                end
            end
            dalift_pkg::PH_GAP,
            dalift_pkg::PH_GAP_NONE:
            begin
                if (tick_next >= cfg.frame_gap_ticks)
                begin
                    res.done_res = 1'b1;
                    if (phase_next == dalift_pkg::PH_GAP)
                    begin
                        res.answer = recv_next;
                    end
                    else
                    begin
                        res.timed_out = 1'b1;
                    end
                    phase_next = dalift_pkg::PH_IDLE;
                    tick_next  = '0;
                end
                else
                begin
                    tick_next = tick_inc;
                end
            end
            default:
            begin
            end
        endcase

        res.line_out = level ^ cfg.invert_tx;
    end

endmodule

### rtl/dali_frame_transceiver_core.sv
// channel | direction | handshake         | payload
// in      | input     | in_valid/in_stall | start_req first_byte second_byte expect_answer line_in
// out     | output    | out_valid/out_stall | line_out busy_res done_res answer timed_out
// cfg     | input     | cfg_we            | cfg_index cfg_data
//
// One beat is one bus tick; one result beat follows each input beat in the next cycle.
// A new beat is taken every cycle unless the output stalls; tick logic is combinational.
// Reset idles the engine (bus released, high) and resets cfg but not the result register.
// A stall on the output holds the result register and stalls the input.
`include "dali_frame_transceiver_core_defines.svh"

module dali_frame_transceiver_core (
    input  logic clk,
    input  logic rst_n,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic       start_req,
    input  logic [7:0] first_byte,
    input  logic [7:0] second_byte,
    input  logic       expect_answer,
    input  logic       line_in,

    output logic       out_valid,
    input  logic       out_stall,
    output logic       line_out,
    output logic       busy_res,
    output logic       done_res,
    output logic [dalift_pkg::ANSWER_BITS-1:0] answer,
    output logic       timed_out,

    input  logic                                   cfg_we,
    input  logic [dalift_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [dalift_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

    dalift_pkg::cfg_t  cfg_reg, cfg_next;
    dalift_pkg::item_t item;
    dalift_pkg::res_t  res;
    dalift_pkg::res_t  res_reg;
    logic              out_valid_reg, out_valid_next;
    logic              in_accept;

    assign in_stall  = out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;

    assign item = '{start_req:     start_req,
                    first_byte:    first_byte,
                    second_byte:   second_byte,
                    expect_answer: expect_answer,
                    line_in:       line_in};

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                dalift_pkg::CFG_HALF_BIT:  cfg_next.half_bit_ticks =
                                               cfg_data[dalift_pkg::HALF_WIDTH-1:0];
                dalift_pkg::CFG_TIMEOUT:   cfg_next.answer_timeout_ticks =
                                               cfg_data[dalift_pkg::COUNT_WIDTH-1:0];
                dalift_pkg::CFG_OFFSET:    cfg_next.sample_offset_ticks =
                                               cfg_data[dalift_pkg::HALF_WIDTH-1:0];
                dalift_pkg::CFG_GAP:       cfg_next.frame_gap_ticks =
                                               cfg_data[dalift_pkg::COUNT_WIDTH-1:0];
                dalift_pkg::CFG_INVERT_TX: cfg_next.invert_tx = cfg_data[0];
                dalift_pkg::CFG_INVERT_RX: cfg_next.invert_rx = cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_bit_ticks       <= 16'd417;
            cfg_reg.answer_timeout_ticks <= 24'd30000;
            cfg_reg.sample_offset_ticks  <= 16'd200;
            cfg_reg.frame_gap_ticks      <= 24'd10000;
            cfg_reg.invert_tx            <= 1'b0;
            cfg_reg.invert_rx            <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    dalift_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (in_accept),
        .cfg     (cfg_reg),
        .item    (item),
        .res     (res)
    );

    // hold the result beat until taken; refill on the same edge it drains
    assign out_valid_next = in_accept | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign line_out  = res_reg.line_out;
    assign busy_res  = res_reg.busy_res;
    assign done_res  = res_reg.done_res;
    assign answer    = res_reg.answer;
    assign timed_out = res_reg.timed_out;

    `DALIFT_ASSERT_NOW(a_done_busy, clk, rst_n, out_valid && done_res, busy_res, "done without busy")
    `DALIFT_ASSERT_NOW(a_timeout_clean, clk, rst_n, out_valid && timed_out,
        done_res && answer == '0, "timeout beat without done or with an answer")
    `DALIFT_ASSERT_NOW(a_idle_released, clk, rst_n, out_valid && !busy_res,
        line_out == !cfg_reg.invert_tx ^ 1'b0 ^ 1'b0 || line_out == (1'b1 ^ cfg_reg.invert_tx),
        "bus driven while idle")
    `DALIFT_ASSERT_NEXT(a_answer_only_done, clk, rst_n, in_accept,
        done_res || answer == '0, "answer shown outside done")

endmodule

### tb/sv/dali_line_checker.sv
`timescale 1ns / 1ps

module dali_line_checker
    import dalift_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic                       start_req,
    input  logic [7:0]                 first_byte,
    input  logic [7:0]                 second_byte,
    input  logic                       expect_answer,
    input  logic                       line_in,

    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic                       line_out,
    input  logic                       busy_res,
    input  logic                       done_res,
    input  logic [ANSWER_BITS-1:0]     answer,
    input  logic                       timed_out,

    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,

    output int                         mismatches,
    output int                         ticks_pending,
    output logic                       frame_idle
);

    // register copies
    logic [HALF_WIDTH-1:0]  half_q;
    logic [COUNT_WIDTH-1:0] tmo_q;
    logic [HALF_WIDTH-1:0]  offs_q;
    logic [COUNT_WIDTH-1:0] gap_q;
    logic                   inv_tx_q;
    logic                   inv_rx_q;

    // transaction state
    phase_t                 ph;
    logic [COUNT_WIDTH-1:0] tick_cnt;
    logic [4:0]             bit_idx;
    logic [FRAME_BITS-1:0]  send_sr;
    logic [ANSWER_BITS-1:0] recv_sr;
    logic                   want_ans;
    logic                   half_sel;

    res_t due_ticks[$];

    function automatic logic [COUNT_WIDTH-1:0] half_len();
        return (half_q == '0) ? COUNT_WIDTH'(1) : COUNT_WIDTH'(half_q);
    endfunction

    // advance within a half-bit; high when it has run out
    function automatic logic half_done();
        tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt >= half_len()) begin
            tick_cnt = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic bus_tick(input logic sr, input logic [7:0] fb, input logic [7:0] sb,
                            input logic ea, input logic li, output res_t r);
        logic                   rx;
        logic                   lvl;
        logic                   bitv;
        logic                   bsy;
        logic                   done;
        logic [ANSWER_BITS-1:0] ans;
        logic                   tout;
        int                     k;
        rx   = li ^ inv_rx_q;
        lvl  = 1'b1;
        done = 1'b0;
        ans  = '0;
        tout = 1'b0;
        if (ph == PH_IDLE && sr) begin
            send_sr  = {fb, sb};
            want_ans = ea;
            recv_sr  = '0;
            tick_cnt = '0;
            bit_idx  = '0;
            half_sel = 1'b0;
            ph       = PH_SEND;
        end
        bsy = (ph != PH_IDLE);

        case (ph)
            PH_SEND: begin
                // index zero is the start bit, then MSB first
                k    = (FRAME_BITS - int'(bit_idx)) & (FRAME_BITS - 1);
                bitv = (bit_idx == '0) ? 1'b1 : send_sr[k];
                lvl  = half_sel ? bitv : ~bitv;
                if (half_done()) begin
                    if (!half_sel) begin
                        half_sel = 1'b1;
                    end else begin
                        half_sel = 1'b0;
                        if (bit_idx >= FRAME_BITS) begin
                            bit_idx = '0;
                            ph      = PH_STOP;
                        end else begin
                            bit_idx = bit_idx + 1'b1;
                        end
                    end
                end
            end
            PH_STOP: begin
                if (half_done()) begin
                    bit_idx = bit_idx + 1'b1;
                    if (bit_idx >= STOP_HALVES) begin
                        bit_idx = '0;
                        if (want_ans) begin
                            ph = PH_WAIT;
                        end else begin
                            done = 1'b1;
                            ph   = PH_IDLE;
                        end
                    end
                end
            end
            PH_WAIT: begin
                if (!rx) begin
                    tick_cnt = '0;
                    bit_idx  = '0;
                    ph       = PH_DELAY;
                end else begin
                    tick_cnt = tick_cnt + 1'b1;
                    if (tick_cnt >= tmo_q) begin
                        tick_cnt = '0;
                        recv_sr  = '0;
                        ph       = PH_GAP_NONE;
                    end
                end
            end
            PH_DELAY: begin
                tick_cnt = tick_cnt + 1'b1;
                if (bit_idx < DELAY_HALVES && tick_cnt >= half_len()) begin
                    tick_cnt = '0;
                    bit_idx  = bit_idx + 1'b1;
                end
                if (bit_idx >= DELAY_HALVES && tick_cnt >= COUNT_WIDTH'(offs_q)) begin
                    recv_sr  = ANSWER_BITS'(rx);
                    bit_idx  = 5'd1;
                    half_sel = 1'b0;
                    tick_cnt = '0;
                    ph       = PH_RECV;
                end
            end
            PH_RECV: begin
                if (half_done()) begin
                    if (!half_sel) begin
                        half_sel = 1'b1;
                    end else begin
                        half_sel = 1'b0;
                        if (bit_idx >= ANSWER_BITS) begin
                            tick_cnt = '0;
                            ph       = PH_GAP;
                        end else begin
                            recv_sr = {recv_sr[ANSWER_BITS-2:0], rx};
                            bit_idx = bit_idx + 1'b1;
                        end
                    end
                end
            end
            PH_GAP, PH_GAP_NONE: begin
                if (tick_cnt >= gap_q) begin
                    done = 1'b1;
                    if (ph == PH_GAP)
                        ans = recv_sr;
                    else
                        tout = 1'b1;
                    ph       = PH_IDLE;
                    tick_cnt = '0;
                end else begin
                    tick_cnt = tick_cnt + 1'b1;
                end
            end
            default: ;
        endcase

        r.line_out  = lvl ^ inv_tx_q;
        r.busy_res  = bsy;
        r.done_res  = done;
        r.answer    = ans;
        r.timed_out = tout;
    endtask

    always @(posedge clk or negedge rst_n) begin
        res_t exp_r;
        res_t got_r;
        res_t nxt_r;
        if (!rst_n) begin
            half_q     = HALF_WIDTH'(417);
            tmo_q      = COUNT_WIDTH'(30000);
            offs_q     = HALF_WIDTH'(200);
            gap_q      = COUNT_WIDTH'(10000);
            inv_tx_q   = 1'b0;
            inv_rx_q   = 1'b0;
            ph         = PH_IDLE;
            tick_cnt   = '0;
            bit_idx    = '0;
            send_sr    = '0;
            recv_sr    = '0;
            want_ans   = 1'b0;
            half_sel   = 1'b0;
            due_ticks.delete();
            mismatches = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_HALF_BIT:  half_q   = cfg_data[HALF_WIDTH-1:0];
                    CFG_TIMEOUT:   tmo_q    = cfg_data[COUNT_WIDTH-1:0];
                    CFG_OFFSET:    offs_q   = cfg_data[HALF_WIDTH-1:0];
                    CFG_GAP:       gap_q    = cfg_data[COUNT_WIDTH-1:0];
                    CFG_INVERT_TX: inv_tx_q = cfg_data[0];
                    CFG_INVERT_RX: inv_rx_q = cfg_data[0];
                    default: ;
                endcase
            end

            // compare before predicting: a beat leaving now belongs to an older tick
            if (out_valid && !out_stall) begin
                got_r = '{line_out, busy_res, done_res, answer, timed_out};
                if (due_ticks.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: result beat with nothing expected: %p", $time, got_r);
                    mismatches++;
                end else begin
                    exp_r = due_ticks.pop_front();
                    if (got_r.line_out !== exp_r.line_out || got_r.busy_res !== exp_r.busy_res
                        || got_r.done_res !== exp_r.done_res || got_r.answer !== exp_r.answer
                        || got_r.timed_out !== exp_r.timed_out) begin
                        if (mismatches < 10)
                            $display("%0t: mismatch expected %p got %p", $time, exp_r, got_r);
                        mismatches++;
                    end
                end
            end

            if (in_valid && !in_stall) begin
                bus_tick(start_req, first_byte, second_byte, expect_answer, line_in, nxt_r);
                due_ticks.push_back(nxt_r);
            end
        end
        ticks_pending = due_ticks.size();
        frame_idle    = (ph == PH_IDLE);
    end

endmodule

### tb/sv/dali_frame_transceiver_core_tb.sv
`timescale 1ns / 1ps

module dali_frame_transceiver_core_tb;

    localparam int LONG_HOLD = 80;
    localparam int WATCHDOG  = 1000;
    localparam int DW        = dalift_pkg::CFG_DATA_WIDTH;

    logic clk;
    logic rst_n;

    logic       in_valid;
    logic       in_stall;
    logic       start_req;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic       expect_answer;
    logic       line_in;

    logic                               out_valid;
    logic                               out_stall = 1'b0;
    logic                               line_out;
    logic                               busy_res;
    logic                               done_res;
    logic [dalift_pkg::ANSWER_BITS-1:0] answer;
    logic                               timed_out;

    logic                                   cfg_we;
    logic [dalift_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [DW-1:0]                          cfg_data;

    int   mismatches;
    int   ticks_pending;
    logic frame_idle;

    bit   quiet      = 1'b0;
    int   hold_reqs  = 0;
    int   hold_seen  = 0;
    int   stall_left = 0;
    logic rx_flip    = 1'b0;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    dali_frame_transceiver_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .start_req     (start_req),
        .first_byte    (first_byte),
        .second_byte   (second_byte),
        .expect_answer (expect_answer),
        .line_in       (line_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .line_out      (line_out),
        .busy_res      (busy_res),
        .done_res      (done_res),
        .answer        (answer),
        .timed_out     (timed_out),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    dali_line_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .start_req     (start_req),
        .first_byte    (first_byte),
        .second_byte   (second_byte),
        .expect_answer (expect_answer),
        .line_in       (line_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .line_out      (line_out),
        .busy_res      (busy_res),
        .done_res      (done_res),
        .answer        (answer),
        .timed_out     (timed_out),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .ticks_pending (ticks_pending),
        .frame_idle    (frame_idle)
    );

    // receiver: random stall bursts, plus one long hold on request
    always @(negedge clk)
    begin
        if (hold_seen != hold_reqs)
        begin
            hold_seen  = hold_reqs;
            stall_left = LONG_HOLD;
        end
        else if (stall_left == 0 && !quiet && $urandom_range(0, 99) < 15)
        begin
            stall_left = int'($urandom_range(1, 8));
        end
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    initial
    begin
        int idle_run;
        idle_run = 0;
        @(posedge rst_n);
        while (idle_run < WATCHDOG)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("dali_frame_transceiver_core_tb: errors");
        $finish;
    end

    // bus level as seen after the receive inversion: low with the given odds
    function automatic logic line_level(int low_pct);
        return (($urandom_range(0, 99) < low_pct) ? 1'b0 : 1'b1) ^ rx_flip;
    endfunction

    task automatic send_tick(input logic sr, input logic [7:0] fb, input logic [7:0] sb,
                             input logic ea, input logic li);
        in_valid      <= 1'b1;
        start_req     <= sr;
        first_byte    <= fb;
        second_byte   <= sb;
        expect_answer <= ea;
        line_in       <= li;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic put_reg(input logic [dalift_pkg::CFG_INDEX_WIDTH-1:0] idx,
                           input logic [DW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
    endtask

    task automatic load_config(input logic [15:0] h, input logic [23:0] t, input logic [15:0] o,
                               input logic [23:0] g, input logic itx, input logic irx);
        in_valid <= 1'b0;
        put_reg(dalift_pkg::CFG_HALF_BIT, DW'(h));
        put_reg(dalift_pkg::CFG_TIMEOUT, t);
        put_reg(dalift_pkg::CFG_OFFSET, DW'(o));
        put_reg(dalift_pkg::CFG_GAP, g);
        put_reg(dalift_pkg::CFG_INVERT_TX, DW'(itx));
        put_reg(dalift_pkg::CFG_INVERT_RX, DW'(irx));
        cfg_we  <= 1'b0;
        rx_flip = irx;
    endtask

    // feed idle ticks until the transaction is over and every beat is back
    task automatic settle_bus(input int low_pct);
        while (!(ticks_pending == 0 && frame_idle))
        begin
            if (frame_idle)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            else
            begin
                send_tick(1'b0, 8'($urandom), 8'($urandom), 1'($urandom), line_level(low_pct));
            end
        end
    endtask

    // one transaction, then a few requests that land while busy
    task automatic frame(input logic [7:0] fb, input logic [7:0] sb, input logic ea,
                         input int low_pct);
        send_tick(1'b1, fb, sb, ea, line_level(low_pct));
        repeat (5)
            send_tick(1'b1, 8'($urandom), 8'($urandom), 1'($urandom), line_level(low_pct));
        settle_bus(low_pct);
    endtask

    task automatic run_random(input int n, input int start_pct, input int want_pct,
                              input int low_pct);
        for (int i = 0; i < n; i++)
        begin
            if (!quiet && $urandom_range(0, 99) < 15)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
            send_tick($urandom_range(0, 99) < start_pct, 8'($urandom), 8'($urandom),
                      $urandom_range(0, 99) < want_pct, line_level(low_pct));
        end
    endtask

    initial
    begin
        in_valid      = 1'b0;
        start_req     = 1'b0;
        first_byte    = '0;
        second_byte   = '0;
        expect_answer = 1'b0;
        line_in       = 1'b1;
        cfg_we        = 1'b0;
        cfg_index     = dalift_pkg::CFG_HALF_BIT;
        cfg_data      = '0;
        rst_n         = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // shortest timing: no answer, answer at once, timeout
        load_config(16'd1, 24'd3, 16'd0, 24'd0, 1'b0, 1'b0);
        frame(8'hFF, 8'h00, 1'b0, 50);
        frame(8'h00, 8'hFF, 1'b1, 100);
        frame(8'hA5, 8'h5A, 1'b1, 0);
        frame(8'h3C, 8'hC3, 1'b1, 50);

        // zero half-bit and zero timeout, both lines inverted
        load_config(16'd0, 24'd0, 16'd3, 24'd2, 1'b1, 1'b1);
        frame(8'h81, 8'h7E, 1'b1, 0);
        frame(8'h12, 8'h34, 1'b1, 100);
        frame(8'hFF, 8'hFF, 1'b0, 50);

        // largest values: stay idle under the longest half-bit
        load_config(16'hFFFF, 24'hFFFFFF, 16'hFFFF, 24'hFFFFFF, 1'b1, 1'b0);
        run_random(20, 0, 50, 50);
        settle_bus(50);

        // largest timeout, offset and gap with forward-only frames
        load_config(16'd1, 24'hFFFFFF, 16'hFFFF, 24'hFFFFFF, 1'b0, 1'b0);
        run_random(30, 30, 0, 50);
        settle_bus(50);

        load_config(16'd1, 24'd6, 16'd1, 24'd3, 1'b0, 1'b0);
        run_random(50, 40, 70, 20);
        settle_bus(20);

        // receiver holds off while ticks keep coming
        load_config(16'd2, 24'd20, 16'd0, 24'd0, 1'b1, 1'b0);
        run_random(20, 30, 80, 10);
        hold_reqs = hold_reqs + 1;
        run_random(30, 30, 80, 10);
        settle_bus(10);

        // sender waits for every beat mid-stream
        load_config(16'd1, 24'd1, 16'd2, 24'd5, 1'b0, 1'b1);
        run_random(20, 40, 70, 40);
        in_valid <= 1'b0;
        while (ticks_pending != 0) @(negedge clk);
        run_random(20, 40, 70, 40);
        settle_bus(40);

        quiet = 1'b1;
        load_config(16'($urandom_range(1, 3)), 24'($urandom_range(0, 30)),
                    16'($urandom_range(0, 4)), 24'($urandom_range(0, 8)),
                    1'($urandom), 1'($urandom));
        run_random(40, 40, 70, 30);
        settle_bus(30);

        in_valid <= 1'b0;
        repeat (4) @(negedge clk);
        if (mismatches == 0)
            $display("dali_frame_transceiver_core_tb: clean");
        else
            $display("dali_frame_transceiver_core_tb: errors");
        $finish;
    end

endmodule
